@@ hdl/fhpf_pkg.sv @@
// Package for the 41-tap high-pass FIR filter unit.
// Holds the filter sizes, the Q1.15 coefficient table and the sequencer state type.
// No dependencies; imported by fir_highpass_filter_unit.
package fhpf_pkg;

	localparam int TAPS         = 41;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH   = 16;
	localparam int ACC_W        = 40;
	localparam int HIST_DEPTH   = TAPS - 1;
	localparam int SHIFT        = COEF_WIDTH - 1;
	localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int TAP_W        = $clog2(TAPS);
	localparam int ADDR_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
	localparam int QUOT_W       = ACC_W - SHIFT;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;

	localparam coef_t COEF_TABLE [TAPS] = '{
		-16'sd37,   16'sd314,   16'sd215,   16'sd121,   16'sd122,
		16'sd396,   16'sd816,   16'sd931,   16'sd384,   -16'sd603,
		-16'sd1265, -16'sd1017, -16'sd195,  16'sd33,    -16'sd1228,
		-16'sd3426, -16'sd4600, -16'sd2909, 16'sd1556,  16'sd6384,
		16'sd8464,
		16'sd6384,  16'sd1556,  -16'sd2909, -16'sd4600, -16'sd3426,
		-16'sd1228, 16'sd33,    -16'sd195,  -16'sd1017, -16'sd1265,
		-16'sd603,  16'sd384,   16'sd931,   16'sd816,   16'sd396,
		16'sd122,   16'sd121,   16'sd215,   16'sd314,   -16'sd37
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_DONE
	} state_t;

endpackage

@@ hdl/fir_highpass_filter_unit.sv @@
// Top level of the 41-tap high-pass FIR filter: sequencer, shared multiply-accumulate
// and output register. Depends on fhpf_pkg and fhpf_ram.
//
// Usage: a request on the sample channel (sample_valid, sample_stall) carries one signed
// 16-bit sample and a block_start flag; block_start makes all earlier history count as
// zero. Each request yields exactly one request on the result channel (result_valid,
// result_stall) carrying the filtered sample and a saturated flag.
// One multiplier is shared over the taps: the sequencer issues one tap per cycle, each
// tap passes the history RAM read register and the product register into the
// accumulator, and a final step in ST_DONE rounds, saturates and writes the new sample
// into the history RAM. sample_stall stays high from acceptance until that final step,
// so a new sample is taken only once the previous one is through.
// The result sits in an output register, so the next sample is accepted while a result
// still waits. If the receiver keeps result_stall high, the following item finishes its
// taps and then holds until the output register is free.
// Reset clears the history count, so the first output after reset is filtered from zero
// history. No clearing pass is needed, as entries beyond the count read as zero.
module fir_highpass_filter_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               sample_valid,
	output logic                               sample_stall,
	input  logic signed [fhpf_pkg::SAMPLE_WIDTH-1:0] sample_in,
	input  logic                               block_start,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic signed [fhpf_pkg::SAMPLE_WIDTH-1:0] sample_out,
	output logic                               saturated
);

	import fhpf_pkg::*;

	state_t state_q, state_d;
	logic accept, issue, finish, out_free;

	logic [TAP_W-1:0]  tap_q;
	logic [ADDR_W-1:0] wptr_q;
	logic [TAP_W-1:0]  count_q;
	sample_t           x_q;

	logic [ADDR_W:0]   rsum;
	logic [ADDR_W-1:0] raddr;
	logic [SAMPLE_WIDTH-1:0] rdata;

	logic              v_s1, last_s1;
	logic [TAP_W-1:0]  tap_s1;
	sample_t           operand;
	logic signed [PROD_W-1:0] prod;

	logic              v_s2, last_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic [ACC_W-1:0]  rnd;
	logic [QUOT_W-1:0] quot;
	logic [QUOT_W-SAMPLE_WIDTH:0] top_bits;
	logic              clip;
	sample_t           result;

	logic              result_valid_q;
	sample_t           sample_out_q;
	logic              saturated_q;

	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		accept  = 1'b0;
		issue   = 1'b0;
		finish  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					accept  = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (tap_q == TAP_W'(TAPS - 1)) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (v_s2 && last_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign sample_stall = (state_q != ST_IDLE);

	// History entry k (newest first) lives at wptr - 1 - k, so tap t reads wptr - t.
	assign rsum  = {1'b0, wptr_q} + (ADDR_W + 1)'(HIST_DEPTH) - (ADDR_W + 1)'(tap_q);
	assign raddr = (rsum >= (ADDR_W + 1)'(HIST_DEPTH)) ?
		ADDR_W'(rsum - (ADDR_W + 1)'(HIST_DEPTH)) : rsum[ADDR_W-1:0];

	fhpf_ram #(
		.WIDTH (SAMPLE_WIDTH),
		.DEPTH (HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (finish),
		.waddr (wptr_q),
		.wdata (x_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Tap zero uses the current sample; history beyond the fill count counts as zero.
	always_comb begin
		if (tap_s1 == '0) begin
			operand = x_q;
		end else if (tap_s1 <= count_q) begin
			operand = sample_t'(rdata);
		end else begin
			operand = '0;
		end
	end

	assign prod = COEF_TABLE[tap_s1] * operand;

	// Round half up, shift, then clip when the quotient leaves the sample range.
	assign rnd      = acc_q + (ACC_W'(1) << (SHIFT - 1));
	assign quot     = rnd[ACC_W-1:SHIFT];
	assign top_bits = quot[QUOT_W-1:SAMPLE_WIDTH-1];
	assign clip     = !((&top_bits) || !(|top_bits));
	always_comb begin
		if (!clip) begin
			result = sample_t'(quot[SAMPLE_WIDTH-1:0]);
		end else if (quot[QUOT_W-1]) begin
			result = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
		end else begin
			result = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q         <= '0;
			count_q        <= '0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (accept && block_start) begin
				count_q <= '0;
			end else if (finish && (count_q < TAP_W'(HIST_DEPTH))) begin
				count_q <= count_q + TAP_W'(1);
			end
			if (finish) begin
				if (wptr_q == ADDR_W'(HIST_DEPTH - 1)) begin
					wptr_q <= '0;
				end else begin
					wptr_q <= wptr_q + ADDR_W'(1);
				end
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q   <= sample_in;
			tap_q <= '0;
		end else if (issue) begin
			tap_q <= tap_q + TAP_W'(1);
		end
		tap_s1  <= tap_q;
		last_s1 <= (tap_q == TAP_W'(TAPS - 1));
		prod_s2 <= prod;
		last_s2 <= last_s1;
		if (accept) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (finish) begin
			sample_out_q <= result;
			saturated_q  <= clip;
		end
	end

	assign result_valid = result_valid_q;
	assign sample_out   = sample_out_q;
	assign saturated    = saturated_q;

endmodule

@@ hdl/fhpf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the sample history of the filter; no dependencies.
module fhpf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 40
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
